@@ hdl/sals_pkg.sv @@
// package: types and constants for the shifting array list store
`timescale 1ns / 1ps

package sals_pkg;

	localparam int CMD_W      = 3;
	localparam int POS_W      = 11;
	localparam int VAL_W      = 32;
	localparam int ST_W       = 2;
	localparam int LEN_W      = 11;
	localparam int IN_DATA_W  = 48;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_USER_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET    = 3'd0,
		CMD_GET    = 3'd1,
		CMD_PUSH   = 3'd2,
		CMD_INSERT = 3'd3,
		CMD_ERASE  = 3'd4,
		CMD_RESIZE = 3'd5
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_EXEC = 8'b0000_0010,
		S_GETW = 8'b0000_0100,
		S_SHUP = 8'b0000_1000,
		S_INSL = 8'b0001_0000,
		S_SHDN = 8'b0010_0000,
		S_CLR  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

endpackage

@@ hdl/shifting_array_list_store_top.sv @@
// top level: list store with one-word-per-cycle shifting through a single memory
// set, push, insert at the end, erase of the last entry and shrink go from execute to result
// get waits on the read; insert inside shifts up, then writes; erase inside shifts down
// resize growing clears the new entries before the result, one cleared entry per cycle
// one command in flight; the shift and clear loops are bound by the single memory write port
// reset clears length, control and output valid; memory content needs no reset pass
`timescale 1ns / 1ps

module shifting_array_list_store_top
	import sals_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // position, value, zero pad
	input  logic [IN_USER_W-1:0]  s_axis_tuser,  // cmd
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // read_value, length, zero pad
	output logic [OUT_USER_W-1:0] m_axis_tuser   // status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);
	localparam int CW = (LW > POS_W) ? LW : POS_W;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rdata_q;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [POS_W-1:0]  pos_q;
	logic [VAL_W-1:0]  val_q;
	logic [LW-1:0]     len_q;
	logic [AW-1:0]     ptr_q;
	logic [VAL_W-1:0]  res_rd_q;
	status_t           res_st_q;
	logic [VAL_W-1:0]  out_rd_q;
	status_t           out_st_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_vld_q;

	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [VAL_W-1:0]  mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;

	logic [CW-1:0]     pos_ext;
	logic [CW-1:0]     len_ext;
	logic [CW-1:0]     ptr_ext;
	logic              pos_lt_len;
	logic              pos_le_len;
	logic              is_full;
	logic              in_xfer;
	logic              out_free;
	logic              up_last;
	logic              dn_last;
	logic              clr_last;

	assign pos_ext    = CW'(pos_q);
	assign len_ext    = CW'(len_q);
	assign ptr_ext    = CW'(ptr_q);
	assign pos_lt_len = pos_ext < len_ext;
	assign pos_le_len = pos_ext <= len_ext;
	assign is_full    = len_ext == CW'(DEPTH);
	assign up_last    = ptr_q == AW'(pos_ext);
	assign dn_last    = ptr_ext == len_ext - CW'(1);
	assign clr_last   = ptr_ext + CW'(1) == pos_ext;

	assign s_axis_tready = state_q == S_IDLE;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - VAL_W - LEN_W){1'b0}}, out_len_q, out_rd_q};
	assign m_axis_tuser  = out_st_q;

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = val_q;
		mem_re = 1'b0;
		mem_ra = '0;
		case (state_q)
			S_EXEC: begin
				case (cmd_q)
					CMD_SET: begin
						mem_we = pos_lt_len;
						mem_wa = AW'(pos_ext);
					end
					CMD_GET: begin
						mem_re = pos_lt_len;
						mem_ra = AW'(pos_ext);
					end
					CMD_PUSH: begin
						mem_we = !is_full;
						mem_wa = AW'(len_ext);
					end
					CMD_INSERT: begin
						if (pos_le_len && !is_full) begin
							if (pos_ext == len_ext) begin
								mem_we = 1'b1;
								mem_wa = AW'(pos_ext);
							end else begin
								mem_re = 1'b1;
								mem_ra = AW'(len_ext - CW'(1));
							end
						end
					end
					CMD_ERASE: begin
						mem_re = pos_lt_len && (pos_ext + CW'(1) != len_ext);
						mem_ra = AW'(pos_ext + CW'(1));
					end
					default: ;
				endcase
			end
			S_SHUP: begin
				mem_we = 1'b1;
				mem_wa = ptr_q + AW'(1);
				mem_wd = rdata_q;
				mem_re = !up_last;
				mem_ra = ptr_q - AW'(1);
			end
			S_INSL: begin
				mem_we = 1'b1;
				mem_wa = AW'(pos_ext);
			end
			S_SHDN: begin
				mem_we = 1'b1;
				mem_wa = ptr_q - AW'(1);
				mem_wd = rdata_q;
				mem_re = !dn_last;
				mem_ra = ptr_q + AW'(1);
			end
			S_CLR: begin
				mem_we = 1'b1;
				mem_wa = ptr_q;
				mem_wd = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q <= cmd_t'(s_axis_tuser[CMD_W-1:0]);
			pos_q <= s_axis_tdata[POS_W-1:0];
			val_q <= s_axis_tdata[POS_W +: VAL_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			len_q     <= '0;
			ptr_q     <= '0;
			res_rd_q  <= '0;
			res_st_q  <= ST_OK;
			out_rd_q  <= '0;
			out_st_q  <= ST_OK;
			out_len_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_rd_q <= '0;
					res_st_q <= ST_OK;
					state_q  <= S_DONE;
					case (cmd_q)
						CMD_SET: begin
							if (!pos_lt_len) begin
								res_st_q <= ST_RANGE;
							end
						end
						CMD_GET: begin
							if (!pos_lt_len) begin
								res_st_q <= ST_RANGE;
							end else begin
								state_q <= S_GETW;
							end
						end
						CMD_PUSH: begin
							if (is_full) begin
								res_st_q <= ST_FULL;
							end else begin
								len_q <= len_q + LW'(1);
							end
						end
						CMD_INSERT: begin
							if (!pos_le_len) begin
								res_st_q <= ST_RANGE;
							end else if (is_full) begin
								res_st_q <= ST_FULL;
							end else if (pos_ext == len_ext) begin
								len_q <= len_q + LW'(1);
							end else begin
								ptr_q   <= AW'(len_ext - CW'(1));
								state_q <= S_SHUP;
							end
						end
						CMD_ERASE: begin
							if (!pos_lt_len) begin
								res_st_q <= ST_RANGE;
							end else if (pos_ext + CW'(1) == len_ext) begin
								len_q <= len_q - LW'(1);
							end else begin
								ptr_q   <= AW'(pos_ext + CW'(1));
								state_q <= S_SHDN;
							end
						end
						CMD_RESIZE: begin
							if (pos_ext > CW'(DEPTH)) begin
								res_st_q <= ST_FULL;
							end else if (pos_ext > len_ext) begin
								ptr_q   <= AW'(len_ext);
								state_q <= S_CLR;
							end else begin
								len_q <= LW'(pos_ext);
							end
						end
						default: ;
					endcase
				end
				S_GETW: begin
					res_rd_q <= rdata_q;
					state_q  <= S_DONE;
				end
				S_SHUP: begin
					if (up_last) begin
						state_q <= S_INSL;
					end else begin
						ptr_q <= ptr_q - AW'(1);
					end
				end
				S_INSL: begin
					len_q   <= len_q + LW'(1);
					state_q <= S_DONE;
				end
				S_SHDN: begin
					if (dn_last) begin
						len_q   <= len_q - LW'(1);
						state_q <= S_DONE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_CLR: begin
					if (clr_last) begin
						len_q   <= LW'(pos_ext);
						state_q <= S_DONE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_rd_q  <= res_rd_q;
						out_st_q  <= res_st_q;
						out_len_q <= LEN_W'(len_ext);
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// live length never passes the store depth
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(len_q) <= CW'(DEPTH))
		else $error("live length above depth");

	// length only moves in states that complete a command
	a_len_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_GETW || state_q == S_SHUP ||
		 state_q == S_DONE) |=> $stable(len_q))
		else $error("length changed outside an update state");

	// upward shift never walks below the insert position
	a_shup_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHUP |-> CW'(ptr_q) >= pos_ext && CW'(ptr_q) < len_ext)
		else $error("insert shift pointer out of window");

	// downward shift stays inside the live list
	a_shdn_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHDN |-> CW'(ptr_q) > pos_ext && CW'(ptr_q) < len_ext)
		else $error("erase shift pointer out of window");

	// a result waiting for the sink is never overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !m_axis_tready |=> out_vld_q && $stable(out_rd_q) &&
		$stable(out_len_q) && $stable(out_st_q))
		else $error("pending result overwritten");

endmodule

@@ dv/shifting_array_list_store_top_test.sv @@
// testbench: streamed list commands against a cycle-free list predictor, with random idling
`timescale 1ns / 1ps

module shifting_array_list_store_top_test;
	import sals_pkg::*;

	localparam int LIST_DEPTH     = 1024;
	localparam int RANDOM_ITEMS   = 555;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int HOLD_AT        = 150;
	localparam int HOLD_CYCLES    = 400;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

	typedef struct {
		logic [CMD_W-1:0] op;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] value;
	} list_command_t;

	typedef struct {
		logic [VAL_W-1:0] read_value;
		status_t          status;
		logic [LEN_W-1:0] length;
	} list_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // position, value, zero pad
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // cmd
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // read_value, length, zero pad
	logic [OUT_USER_W-1:0] m_axis_tuser;        // status

	logic [VAL_W-1:0] store_model [LIST_DEPTH];
	int               store_len;
	list_command_t    pending_commands[$];
	list_result_t     expected_results[$];

	int queued_count;
	int accepted_count;
	int results_seen;
	int error_count;
	int cmd_count [8];
	int status_count [3];
	int burst_left;
	int gap_left;
	int rx_cycle;
	int hold_left;
	bit hold_done;
	int idle_cycles;

	shifting_array_list_store_top #(
		.DEPTH(LIST_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// list behavior: updates the shadow store and returns the result of one command
	function automatic list_result_t apply_command(input logic [CMD_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val);
		list_result_t res;
		res.read_value = '0;
		res.status = ST_OK;
		case (op)
			CMD_SET: begin
				if (pos >= store_len)
					res.status = ST_RANGE;
				else
					store_model[pos] = val;
			end
			CMD_GET: begin
				if (pos >= store_len)
					res.status = ST_RANGE;
				else
					res.read_value = store_model[pos];
			end
			CMD_PUSH: begin
				if (store_len >= LIST_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					store_model[store_len] = val;
					store_len++;
				end
			end
			CMD_INSERT: begin
				if (pos > store_len) begin
					res.status = ST_RANGE;
				end else if (store_len >= LIST_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (int i = store_len; i > pos; i--)
						store_model[i] = store_model[i - 1];
					store_model[pos] = val;
					store_len++;
				end
			end
			CMD_ERASE: begin
				if (pos >= store_len) begin
					res.status = ST_RANGE;
				end else begin
					for (int i = pos; i + 1 < store_len; i++)
						store_model[i] = store_model[i + 1];
					store_len--;
				end
			end
			CMD_RESIZE: begin
				if (pos > LIST_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (int i = store_len; i < pos; i++)
						store_model[i] = '0;
					store_len = int'(pos);
				end
			end
			default: ;
		endcase
		res.length = store_len[LEN_W-1:0];
		return res;
	endfunction

	task automatic queue_command(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		list_command_t c;
		c.op = op;
		c.position = pos;
		c.value = val;
		pending_commands = {pending_commands, c};
		queued_count++;
	endtask

	// sender: bursts of transfers with random gaps, prediction at each accepted command
	always @(posedge clk or negedge arst_n) begin
		list_command_t next;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			burst_left <= 8;
			gap_left <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results = {expected_results, apply_command(s_axis_tuser,
						s_axis_tdata[10:0], s_axis_tdata[42:11])};
				cmd_count[s_axis_tuser]++;
				accepted_count++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_commands.size() > 0) begin
					next = pending_commands.pop_front();
					s_axis_tdata <= {5'b0, next.value, next.position};
					s_axis_tuser <= next.op;
					s_axis_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: changing stall patterns plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_cycle <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				case (rx_cycle[9:8])
					2'd0: m_axis_tready <= 1'b1;
					2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					2'd2: m_axis_tready <= ((rx_cycle % 5) < 2);
					default: m_axis_tready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	// monitor: compare each result transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		list_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d status %0d len %0d",
						$time, $signed(m_axis_tdata[31:0]), m_axis_tuser, m_axis_tdata[42:32]);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				status_count[want.status]++;
				if (m_axis_tdata[31:0] !== want.read_value) begin
					$display("%0t: read_value mismatch, expected %0d actual %0d", $time,
							$signed(want.read_value), $signed(m_axis_tdata[31:0]));
					error_count++;
				end
				if (m_axis_tuser !== want.status) begin
					$display("%0t: status mismatch, expected %0d actual %0d", $time,
							want.status, m_axis_tuser);
					error_count++;
				end
				if (m_axis_tdata[42:32] !== want.length) begin
					$display("%0t: length mismatch, expected %0d actual %0d", $time,
							want.length, m_axis_tdata[42:32]);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d predictions outstanding", $time,
					idle_cycles, expected_results.size());
			$display("shifting_array_list_store_top test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [CMD_W-1:0] op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		int r;
		int len;

		foreach (store_model[i])
			store_model[i] = '0;
		store_len = 0;

		// empty list, extremes, append, middle insert and erase
		queue_command(CMD_GET, 0, 0);
		queue_command(CMD_ERASE, 0, 0);
		queue_command(CMD_SET, 0, 32'h1234_5678);
		queue_command(CMD_INSERT, 1, 32'h1);
		queue_command(CMD_INSERT, 0, 32'h7FFF_FFFF);
		queue_command(CMD_PUSH, 0, 32'h8000_0000);
		queue_command(CMD_INSERT, 2, 32'hFFFF_FFFF);
		queue_command(CMD_INSERT, 1, 32'h5555_5555);
		queue_command(CMD_GET, 1, 0);
		queue_command(CMD_GET, 3, 0);
		queue_command(CMD_GET, 4, 0);
		queue_command(CMD_SET, 0, 32'hAAAA_AAAA);
		queue_command(CMD_ERASE, 1, 0);
		queue_command(CMD_ERASE, 2, 0);
		// resize limits and a full store
		queue_command(CMD_RESIZE, 11'd2047, 0);
		queue_command(CMD_RESIZE, POS_W'(LIST_DEPTH + 1), 0);
		queue_command(CMD_RESIZE, POS_W'(LIST_DEPTH), 0);
		queue_command(CMD_GET, POS_W'(LIST_DEPTH - 1), 0);
		queue_command(CMD_PUSH, 0, 32'hDEAD_BEEF);
		queue_command(CMD_INSERT, POS_W'(LIST_DEPTH + 1), 32'h1);
		queue_command(CMD_INSERT, POS_W'(LIST_DEPTH), 32'h2);
		queue_command(CMD_INSERT, 0, 32'h3);
		queue_command(CMD_UNUSED_LO, 11'd2047, 32'hFFFF_FFFF);
		queue_command(CMD_UNUSED_HI, 0, 0);
		queue_command(CMD_ERASE, 0, 0);
		queue_command(CMD_RESIZE, 0, 0);
		queue_command(CMD_RESIZE, 5, 0);
		queue_command(CMD_GET, 4, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			wait (pending_commands.size() < 2);
			len = store_len;
			r = $urandom_range(0, 99);
			if (r < 14)
				op = CMD_SET;
			else if (r < 30)
				op = CMD_GET;
			else if (r < 44)
				op = CMD_PUSH;
			else if (r < 60)
				op = CMD_INSERT;
			else if (r < 74)
				op = CMD_ERASE;
			else if (r < 86)
				op = CMD_RESIZE;
			else if (r < 90)
				op = $urandom_range(0, 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
			else
				op = CMD_GET;

			r = $urandom_range(0, 39);
			if (op == CMD_RESIZE) begin
				// mostly short lists, now and then full size or beyond
				if (r == 0)
					pos = POS_W'(LIST_DEPTH);
				else if (r == 1)
					pos = POS_W'($urandom_range(LIST_DEPTH + 1, 2047));
				else if (r == 2)
					pos = POS_W'($urandom_range(0, LIST_DEPTH));
				else
					pos = POS_W'($urandom_range(0, 48));
			end else if (r < 2) begin
				pos = POS_W'($urandom_range(0, 2047));
			end else if (r < 4) begin
				pos = POS_W'(len + int'($urandom_range(0, 3)));
			end else if (op == CMD_INSERT) begin
				pos = POS_W'($urandom_range(0, len));
			end else begin
				pos = (len == 0) ? '0 : POS_W'($urandom_range(0, len - 1));
			end

			case ($urandom_range(0, 9))
				0: val = 32'h8000_0000;
				1: val = 32'h7FFF_FFFF;
				2: val = '0;
				3: val = '1;
				default: val = $urandom;
			endcase
			queue_command(op, pos, val);
		end

		wait (accepted_count == queued_count);
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d commands: set %0d get %0d push %0d insert %0d erase %0d resize %0d unused %0d",
				accepted_count, cmd_count[CMD_SET], cmd_count[CMD_GET], cmd_count[CMD_PUSH],
				cmd_count[CMD_INSERT], cmd_count[CMD_ERASE], cmd_count[CMD_RESIZE],
				cmd_count[CMD_UNUSED_LO] + cmd_count[CMD_UNUSED_HI]);
		$display("results: ok %0d, out of range %0d, full %0d, mismatches %0d",
				status_count[ST_OK], status_count[ST_RANGE], status_count[ST_FULL], error_count);
		if (error_count == 0)
			$display("shifting_array_list_store_top test passed");
		else
			$display("shifting_array_list_store_top test failed");
		$finish;
	end

endmodule
